FILE: hw/rtl/terminal_damage_diff_encoder_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef TERMINAL_DAMAGE_DIFF_ENCODER_UNIT_MACROS_SVH
`define TERMINAL_DAMAGE_DIFF_ENCODER_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define TDDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TDDE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tdde_pkg.sv
package tdde_pkg;

    // Screen limits; cells outside them are dropped
    localparam int unsigned MAX_ROWS = 256;
    localparam int unsigned MAX_COLS = 256;

    localparam logic [3:0]  DEFAULT_COLOR_RESET = 4'd9;
    localparam logic [15:0] ATTR_UNKNOWN        = 16'hFFFF;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

    // Byte slots of the longest possible run, in emission order
    localparam int unsigned NUM_SLOTS = 25;
    localparam logic [4:0] SLOT_MV_ESC   = 5'd0;
    localparam logic [4:0] SLOT_MV_CSI   = 5'd1;
    localparam logic [4:0] SLOT_ROW_H    = 5'd2;
    localparam logic [4:0] SLOT_ROW_T    = 5'd3;
    localparam logic [4:0] SLOT_ROW_O    = 5'd4;
    localparam logic [4:0] SLOT_MV_SEP   = 5'd5;
    localparam logic [4:0] SLOT_COL_H    = 5'd6;
    localparam logic [4:0] SLOT_COL_T    = 5'd7;
    localparam logic [4:0] SLOT_COL_O    = 5'd8;
    localparam logic [4:0] SLOT_MV_END   = 5'd9;
    localparam logic [4:0] SLOT_SGR_ESC  = 5'd10;
    localparam logic [4:0] SLOT_SGR_CSI  = 5'd11;
    localparam logic [4:0] SLOT_SGR_RST  = 5'd12;
    localparam logic [4:0] SLOT_SGR_SEP0 = 5'd13;
    localparam logic [4:0] SLOT_BOLD     = 5'd14;
    localparam logic [4:0] SLOT_BOLD_SEP = 5'd15;
    localparam logic [4:0] SLOT_FG_T     = 5'd16;
    localparam logic [4:0] SLOT_FG_O     = 5'd17;
    localparam logic [4:0] SLOT_SGR_SEP1 = 5'd18;
    localparam logic [4:0] SLOT_BG_T     = 5'd19;
    localparam logic [4:0] SLOT_BG_O     = 5'd20;
    localparam logic [4:0] SLOT_SGR_END  = 5'd21;
    localparam logic [4:0] SLOT_GLYPH0   = 5'd22;
    localparam logic [4:0] SLOT_GLYPH1   = 5'd23;
    localparam logic [4:0] SLOT_GLYPH2   = 5'd24;

    // Stream characters
    localparam logic [7:0] CHR_ESC  = 8'h1B;
    localparam logic [7:0] CHR_CSI  = 8'h5B;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_ONE  = 8'h31;
    localparam logic [7:0] CHR_H    = 8'h48;
    localparam logic [7:0] CHR_M    = 8'h6D;

    // UTF-8 marks
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    // One classified cell: which slots to emit and what goes into them
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [3:0] row_h;
        logic [3:0] row_t;
        logic [3:0] row_o;
        logic [3:0] col_h;
        logic [3:0] col_t;
        logic [3:0] col_o;
        logic [3:0] fg_t;
        logic [3:0] fg_o;
        logic [3:0] bg_t;
        logic [3:0] bg_o;
        logic [7:0] glyph0;
        logic [7:0] glyph1;
        logic [7:0] glyph2;
    } cmd_t;

endpackage

FILE: hw/rtl/tdde_ifs.sv
interface tdde_cell_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] new_glyph;
    logic [15:0] new_attr;
    logic [15:0] old_glyph;
    logic [15:0] old_attr;

    modport source (
        output valid, frame_start, row, column, new_glyph, new_attr, old_glyph, old_attr,
        input  ready
    );
    modport sink (
        input  valid, frame_start, row, column, new_glyph, new_attr, old_glyph, old_attr,
        output ready
    );
endinterface

interface tdde_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] term_byte;
    logic       last_of_item;

    modport source (
        output valid, term_byte, last_of_item,
        input  ready
    );
    modport sink (
        input  valid, term_byte, last_of_item,
        output ready
    );
endinterface

interface tdde_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] default_color;

    modport source (
        output valid, default_color,
        input  ready
    );
    modport sink (
        input  valid, default_color,
        output ready
    );
endinterface

FILE: hw/rtl/tdde_queue.sv
module tdde_queue import tdde_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/tdde_front.sv
module tdde_front import tdde_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tdde_cell_if.sink     cells,
    input  logic [3:0]    default_color,
    input  logic          queue_full,
    output logic          push,
    output cmd_t          push_cmd
);

    localparam logic [9:0] ROW_LIMIT = 10'(MAX_ROWS);
    localparam logic [9:0] COL_LIMIT = 10'(MAX_COLS);

    typedef struct packed {
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } dec3_t;

    typedef struct packed {
        logic [3:0] ten;
        logic [3:0] one;
    } code_t;

    // Split a value below 300 into decimal digits
    function automatic dec3_t to_dec3(input logic [8:0] v);
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [6:0]  tens10;
        dec3_t       d;
        if (v >= 9'd200)
        begin
            d.hun = 4'd2;
            rem   = 7'(v - 9'd200);
        end
        else if (v >= 9'd100)
        begin
            d.hun = 4'd1;
            rem   = 7'(v - 9'd100);
        end
        else
        begin
            d.hun = 4'd0;
            rem   = v[6:0];
        end
        // rem / 10 by reciprocal, exact for rem below 100
        prod   = 15'(rem) * 15'd205;
        d.ten  = prod[14:11];
        tens10 = 7'(d.ten) * 7'd10;
        d.one  = 4'(rem - tens10);
        return d;
    endfunction

    // SGR color code: default color maps to base*10+9, else base*10+idx
    function automatic code_t color_code(input logic [3:0] idx, input logic [3:0] dflt,
                                         input logic [3:0] base);
        code_t c;
        if (idx == dflt)
        begin
            c.ten = base;
            c.one = 4'd9;
        end
        else if (idx < 4'd10)
        begin
            c.ten = base;
            c.one = idx;
        end
        else
        begin
            c.ten = base + 4'd1;
            c.one = idx - 4'd10;
        end
        return c;
    endfunction

    logic [15:0] attr_reg;
    logic [15:0] attr_next;
    logic        prev_drawn_reg;
    logic        prev_drawn_next;
    logic        accept;
    logic [15:0] attr_eff;
    logic        prev_eff;
    logic        in_range;
    logic        changed;
    logic        draw;
    logic        need_move;
    logic        need_sgr;
    dec3_t       row_dec;
    dec3_t       col_dec;
    code_t       fg_code;
    code_t       bg_code;
    logic [15:0] g;

    assign cells.ready = !queue_full;
    assign accept      = cells.valid && cells.ready;
    assign g           = cells.new_glyph;

    // Classify the cell against the asserted state
    always_comb
    begin
        attr_eff  = cells.frame_start ? ATTR_UNKNOWN : attr_reg;
        prev_eff  = cells.frame_start ? 1'b0 : prev_drawn_reg;
        in_range  = ({2'b00, cells.row} < ROW_LIMIT) && ({2'b00, cells.column} < COL_LIMIT);
        changed   = (cells.new_glyph != cells.old_glyph) || (cells.new_attr != cells.old_attr);
        draw      = in_range && changed;
        need_move = (cells.column == 8'd0) || !prev_eff;
        need_sgr  = (cells.new_attr != attr_eff);
        push      = accept && draw;

        attr_next       = (draw && need_sgr) ? cells.new_attr : attr_eff;
        prev_drawn_next = draw;
    end

    // Build the slot mask and slot contents
    always_comb
    begin
        row_dec = to_dec3({1'b0, cells.row} + 9'd1);
        col_dec = to_dec3({1'b0, cells.column} + 9'd1);
        fg_code = color_code(cells.new_attr[3:0], default_color, 4'd3);
        bg_code = color_code(cells.new_attr[7:4], default_color, 4'd4);

        push_cmd       = '0;
        push_cmd.row_h = row_dec.hun;
        push_cmd.row_t = row_dec.ten;
        push_cmd.row_o = row_dec.one;
        push_cmd.col_h = col_dec.hun;
        push_cmd.col_t = col_dec.ten;
        push_cmd.col_o = col_dec.one;
        push_cmd.fg_t  = fg_code.ten;
        push_cmd.fg_o  = fg_code.one;
        push_cmd.bg_t  = bg_code.ten;
        push_cmd.bg_o  = bg_code.one;

        if (need_move)
        begin
            push_cmd.mask[SLOT_MV_ESC] = 1'b1;
            push_cmd.mask[SLOT_MV_CSI] = 1'b1;
            push_cmd.mask[SLOT_ROW_H]  = (row_dec.hun != 4'd0);
            push_cmd.mask[SLOT_ROW_T]  = (row_dec.hun != 4'd0) || (row_dec.ten != 4'd0);
            push_cmd.mask[SLOT_ROW_O]  = 1'b1;
            push_cmd.mask[SLOT_MV_SEP] = 1'b1;
            push_cmd.mask[SLOT_COL_H]  = (col_dec.hun != 4'd0);
            push_cmd.mask[SLOT_COL_T]  = (col_dec.hun != 4'd0) || (col_dec.ten != 4'd0);
            push_cmd.mask[SLOT_COL_O]  = 1'b1;
            push_cmd.mask[SLOT_MV_END] = 1'b1;
        end
        if (need_sgr)
        begin
            push_cmd.mask[SLOT_SGR_ESC]  = 1'b1;
            push_cmd.mask[SLOT_SGR_CSI]  = 1'b1;
            push_cmd.mask[SLOT_SGR_RST]  = 1'b1;
            push_cmd.mask[SLOT_SGR_SEP0] = 1'b1;
            push_cmd.mask[SLOT_BOLD]     = cells.new_attr[8];
            push_cmd.mask[SLOT_BOLD_SEP] = cells.new_attr[8];
            push_cmd.mask[SLOT_FG_T]     = 1'b1;
            push_cmd.mask[SLOT_FG_O]     = 1'b1;
            push_cmd.mask[SLOT_SGR_SEP1] = 1'b1;
            push_cmd.mask[SLOT_BG_T]     = 1'b1;
            push_cmd.mask[SLOT_BG_O]     = 1'b1;
            push_cmd.mask[SLOT_SGR_END]  = 1'b1;
        end

        // UTF-8 encode the glyph
        push_cmd.mask[SLOT_GLYPH0] = 1'b1;
        if (g < 16'h0080)
        begin
            push_cmd.glyph0 = g[7:0];
        end
        else if (g < 16'h0800)
        begin
            push_cmd.mask[SLOT_GLYPH1] = 1'b1;
            push_cmd.glyph0 = UTF_LEAD2 | {3'b000, g[10:6]};
            push_cmd.glyph1 = UTF_CONT | {2'b00, g[5:0]};
        end
        else
        begin
            push_cmd.mask[SLOT_GLYPH1] = 1'b1;
            push_cmd.mask[SLOT_GLYPH2] = 1'b1;
            push_cmd.glyph0 = UTF_LEAD3 | {4'b0000, g[15:12]};
            push_cmd.glyph1 = UTF_CONT | {2'b00, g[11:6]};
            push_cmd.glyph2 = UTF_CONT | {2'b00, g[5:0]};
        end
    end

    // Update asserted attribute and run state per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg       <= ATTR_UNKNOWN;
            prev_drawn_reg <= 1'b0;
        end
        else if (accept)
        begin
            attr_reg       <= attr_next;
            prev_drawn_reg <= prev_drawn_next;
        end
    end

endmodule

FILE: hw/rtl/tdde_back.sv
module tdde_back import tdde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         queue_empty,
    input  cmd_t         head,
    output logic         pop,
    tdde_byte_if.source  stream
);

    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] done_next;
    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] low_bit;
    logic [4:0]           sel;
    logic                 last;
    logic                 load;
    logic                 out_valid_reg;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 last_reg;

    assign stream.valid        = out_valid_reg;
    assign stream.term_byte    = byte_reg;
    assign stream.last_of_item = last_reg;

    // Pick the lowest slot still to be sent for the head command
    always_comb
    begin
        remaining = head.mask & ~done_reg;
        low_bit   = remaining & (~remaining + 1'b1);
        last      = ((remaining & ~low_bit) == '0);
        sel       = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                sel = 5'(i);
            end
        end
        load      = !queue_empty && (!out_valid_reg || stream.ready);
        pop       = load && last;
        done_next = last ? '0 : (done_reg | low_bit);
    end

    // Map the slot to its byte
    always_comb
    begin
        case (sel)
            SLOT_MV_ESC, SLOT_SGR_ESC:                    byte_next = CHR_ESC;
            SLOT_MV_CSI, SLOT_SGR_CSI:                    byte_next = CHR_CSI;
            SLOT_MV_SEP, SLOT_SGR_SEP0, SLOT_BOLD_SEP,
            SLOT_SGR_SEP1:                                byte_next = CHR_SEMI;
            SLOT_ROW_H:   byte_next = CHR_ZERO | {4'b0000, head.row_h};
            SLOT_ROW_T:   byte_next = CHR_ZERO | {4'b0000, head.row_t};
            SLOT_ROW_O:   byte_next = CHR_ZERO | {4'b0000, head.row_o};
            SLOT_COL_H:   byte_next = CHR_ZERO | {4'b0000, head.col_h};
            SLOT_COL_T:   byte_next = CHR_ZERO | {4'b0000, head.col_t};
            SLOT_COL_O:   byte_next = CHR_ZERO | {4'b0000, head.col_o};
            SLOT_MV_END:  byte_next = CHR_H;
            SLOT_SGR_RST: byte_next = CHR_ZERO;
            SLOT_BOLD:    byte_next = CHR_ONE;
            SLOT_FG_T:    byte_next = CHR_ZERO | {4'b0000, head.fg_t};
            SLOT_FG_O:    byte_next = CHR_ZERO | {4'b0000, head.fg_o};
            SLOT_BG_T:    byte_next = CHR_ZERO | {4'b0000, head.bg_t};
            SLOT_BG_O:    byte_next = CHR_ZERO | {4'b0000, head.bg_o};
            SLOT_SGR_END: byte_next = CHR_M;
            SLOT_GLYPH0:  byte_next = head.glyph0;
            SLOT_GLYPH1:  byte_next = head.glyph1;
            SLOT_GLYPH2:  byte_next = head.glyph2;
            default:      byte_next = head.glyph0;
        endcase
    end

    // Hold the output register while stalled, refill when it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            if (!out_valid_reg || stream.ready)
            begin
                out_valid_reg <= !queue_empty;
            end
            if (load)
            begin
                done_reg <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last;
        end
    end

endmodule

FILE: hw/rtl/terminal_damage_diff_encoder_unit.sv
// Terminal damage-diff encoder.
// cells (sink): one screen cell per transaction in row-major order, with its
//   wanted and on-screen glyph and attribute. Changed cells are classified in
//   the cycle they are accepted and queued as one command each.
// stream (source): the terminal byte stream, one byte per transaction;
//   last_of_item marks the final byte of a cell. Unchanged or out-of-range
//   cells produce no bytes.
// cfg (sink): writes default_color; always ready. Write only while idle.
// Path: an accepted cell is written into the command queue, and its first
//   byte then passes through the output register before it is valid.
// Throughput: a cell is accepted every cycle while the command queue has
//   room; the output drains one byte per cycle while stream.ready is high,
//   so a changed cell emits 1 to 25 bytes (cursor move, SGR, UTF-8 glyph).
// Reset: asserted attribute unknown, no run open, default_color 9, queue empty.
// Stall: while stream.ready is low the byte holds; the queue (QUEUE_DEPTH
//   commands) absorbs cells until full, then cells.ready drops.
module terminal_damage_diff_encoder_unit import tdde_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    tdde_cell_if.sink   cells,
    tdde_byte_if.source stream,
    tdde_cfg_if.sink    cfg
);

    logic [3:0] default_color_reg;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    logic       queue_full;
    logic       queue_empty;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= DEFAULT_COLOR_RESET;
        end
        else if (cfg.valid)
        begin
            default_color_reg <= cfg.default_color;
        end
    end

    tdde_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cells         (cells),
        .default_color (default_color_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    tdde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    tdde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .stream      (stream)
    );

endmodule

FILE: hw/rtl/tdde_checker.sv
`include "terminal_damage_diff_encoder_unit_macros.svh"

module tdde_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       stream_valid,
    input logic       stream_ready,
    input logic [7:0] stream_term_byte,
    input logic       stream_last_of_item
);

    // Stalled byte stays offered
    `TDDE_ASSERT(a_valid_hold, stream_valid && !stream_ready |=> stream_valid, "byte dropped while stalled")

    // Stalled byte keeps its value
    `TDDE_ASSERT(a_payload_hold, stream_valid && !stream_ready |=> $stable(stream_term_byte) && $stable(stream_last_of_item), "byte changed while stalled")

    // Output stays quiet in reset
    `TDDE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !stream_valid, "output valid during reset")

    // A UTF-8 lead byte always has continuation bytes behind it
    `TDDE_ASSERT(a_lead_not_last, stream_valid && (stream_term_byte[7:6] == 2'b11) |-> !stream_last_of_item, "lead byte closes a cell")

endmodule

bind terminal_damage_diff_encoder_unit tdde_checker u_tdde_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .stream_valid        (stream.valid),
    .stream_ready        (stream.ready),
    .stream_term_byte    (stream.term_byte),
    .stream_last_of_item (stream.last_of_item)
);
